// File: src/ps2md_pkg.sv
// ----------------------------------------------------------------------------
// ps2md_pkg
// Shared types and constants of the PS/2 mouse packet decoder.
// ----------------------------------------------------------------------------
package ps2md_pkg;

    // Device ids that change packet decoding
    localparam logic [7:0] ID_STANDARD    = 8'd0;
    localparam logic [7:0] ID_WHEEL       = 8'd3;
    localparam logic [7:0] ID_FIVE_BUTTON = 8'd4;

    // Bits of the first packet byte
    localparam int SYNC_BIT   = 3;
    localparam int X_SIGN_BIT = 4;
    localparam int Y_SIGN_BIT = 5;
    localparam int X_OVF_BIT  = 6;
    localparam int Y_OVF_BIT  = 7;

    // Extra button bits of the fourth byte
    localparam int BTN4_BIT = 4;
    localparam int BTN5_BIT = 5;

    localparam int NUM_BUTTONS = 6;

    // Event slots of one packet, in delivery order
    localparam int NUM_SLOTS   = 6;
    localparam int SLOT_BTN0   = 0;
    localparam int SLOT_BTN1   = 1;
    localparam int SLOT_BTN2   = 2;
    localparam int SLOT_BTN4   = 3;
    localparam int SLOT_BTN5   = 4;
    localparam int SLOT_MOTION = 5;

    typedef enum logic [1:0] {
        POS_FIRST  = 2'd0,
        POS_SECOND = 2'd1,
        POS_THIRD  = 2'd2,
        POS_FOURTH = 2'd3
    } ps2md_pos_t;

    typedef enum logic {
        EVENT_BUTTON = 1'b0,
        EVENT_MOTION = 1'b1
    } ps2md_kind_t;

    // Events pending from one completed packet
    typedef struct packed {
        logic [NUM_SLOTS-1:0]   mask;
        logic [NUM_SLOTS-2:0]   down;
        logic signed [8:0]      move_x;
        logic signed [8:0]      move_y;
        logic signed [7:0]      move_wheel;
    } ps2md_batch_t;

    // Button number reported for each button slot
    function automatic logic [2:0] slot_button(input logic [2:0] slot);
        logic [2:0] idx;
        case (slot)
            3'd0:    idx = 3'd0;
            3'd1:    idx = 3'd1;
            3'd2:    idx = 3'd2;
            3'd3:    idx = 3'd4;
            3'd4:    idx = 3'd5;
            default: idx = 3'd0;
        endcase
        return idx;
    endfunction

endpackage

// File: src/ps2md_byte_if.sv
// ----------------------------------------------------------------------------
// ps2md_byte_if
// Controller byte channel: one data port byte and its source flag.
// ----------------------------------------------------------------------------
interface ps2md_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       from_aux;

    modport source (output valid, output data_byte, output from_aux, input ready);
    modport sink (input valid, input data_byte, input from_aux, output ready);
endinterface

// File: src/ps2md_event_if.sv
// ----------------------------------------------------------------------------
// ps2md_event_if
// Mouse event channel: button changes and relative motion.
// ----------------------------------------------------------------------------
interface ps2md_event_if;
    logic              valid;
    logic              ready;
    logic              event_kind;
    logic [2:0]        button_index;
    logic              pressed;
    logic signed [8:0] move_x;
    logic signed [8:0] move_y;
    logic signed [7:0] move_wheel;
    logic              last;

    modport source (
        output valid, output event_kind, output button_index, output pressed,
        output move_x, output move_y, output move_wheel, output last,
        input ready
    );
    modport sink (
        input valid, input event_kind, input button_index, input pressed,
        input move_x, input move_y, input move_wheel, input last,
        output ready
    );
endinterface

// File: src/ps2md_assembler.sv
// ----------------------------------------------------------------------------
// ps2md_assembler
// Collects packet bytes, tracks button state and builds the event batch of
// a completed packet.
// ----------------------------------------------------------------------------
module ps2md_assembler (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic [7:0]             data_byte,
    input  logic                   from_aux,
    input  logic [7:0]             device_id,
    output ps2md_pkg::ps2md_batch_t batch
);

    ps2md_pkg::ps2md_pos_t pos_reg;
    ps2md_pkg::ps2md_pos_t pos_next;
    logic [7:0]            b0_reg, b0_next;
    logic [7:0]            b1_reg, b1_next;
    logic [7:0]            b2_reg, b2_next;
    logic [5:0]            btn_reg, btn_next;

    logic       take;
    logic       finish;
    logic [7:0] b2_eff;
    logic [7:0] b3;
    logic       five_button;

    assign take        = accept && from_aux;
    assign five_button = (device_id == ps2md_pkg::ID_FIVE_BUTTON);

    // Next byte position
    always_comb
    begin
        pos_next = pos_reg;
        finish   = 1'b0;
        if (take)
        begin
            case (pos_reg)
                ps2md_pkg::POS_FIRST:
                begin
                    // drop out-of-sync bytes
                    if (data_byte[ps2md_pkg::SYNC_BIT])
                        pos_next = ps2md_pkg::POS_SECOND;
                end
                ps2md_pkg::POS_SECOND:
                    pos_next = ps2md_pkg::POS_THIRD;
                ps2md_pkg::POS_THIRD:
                begin
                    if (device_id != ps2md_pkg::ID_STANDARD)
                        pos_next = ps2md_pkg::POS_FOURTH;
                    else
                    begin
                        pos_next = ps2md_pkg::POS_FIRST;
                        finish   = 1'b1;
                    end
                end
                ps2md_pkg::POS_FOURTH:
                begin
                    pos_next = ps2md_pkg::POS_FIRST;
                    finish   = 1'b1;
                end
                default:
                    pos_next = ps2md_pkg::POS_FIRST;
            endcase
        end
    end

    // Packet bytes, button state and events
    always_comb
    begin
        b0_next  = b0_reg;
        b1_next  = b1_reg;
        b2_next  = b2_reg;
        btn_next = btn_reg;
        batch    = '0;
        b2_eff   = (pos_reg == ps2md_pkg::POS_THIRD) ? data_byte : b2_reg;
        b3       = (pos_reg == ps2md_pkg::POS_FOURTH) ? data_byte : 8'd0;

        if (take)
        begin
            case (pos_reg)
                ps2md_pkg::POS_FIRST:
                    if (data_byte[ps2md_pkg::SYNC_BIT])
                        b0_next = data_byte;
                ps2md_pkg::POS_SECOND:
                    b1_next = data_byte;
                ps2md_pkg::POS_THIRD:
                    b2_next = data_byte;
                default:
                    b0_next = b0_reg;
            endcase
        end

        if (finish)
        begin
            batch.mask[ps2md_pkg::SLOT_BTN0] = b0_reg[0] ^ btn_reg[0];
            batch.mask[ps2md_pkg::SLOT_BTN1] = b0_reg[1] ^ btn_reg[1];
            batch.mask[ps2md_pkg::SLOT_BTN2] = b0_reg[2] ^ btn_reg[2];
            batch.down[ps2md_pkg::SLOT_BTN0] = b0_reg[0];
            batch.down[ps2md_pkg::SLOT_BTN1] = b0_reg[1];
            batch.down[ps2md_pkg::SLOT_BTN2] = b0_reg[2];
            btn_next[2:0] = b0_reg[2:0];

            if (five_button)
            begin
                batch.mask[ps2md_pkg::SLOT_BTN4] = b3[ps2md_pkg::BTN4_BIT] ^ btn_reg[4];
                batch.mask[ps2md_pkg::SLOT_BTN5] = b3[ps2md_pkg::BTN5_BIT] ^ btn_reg[5];
                batch.down[ps2md_pkg::SLOT_BTN4] = b3[ps2md_pkg::BTN4_BIT];
                batch.down[ps2md_pkg::SLOT_BTN5] = b3[ps2md_pkg::BTN5_BIT];
                btn_next[4] = b3[ps2md_pkg::BTN4_BIT];
                btn_next[5] = b3[ps2md_pkg::BTN5_BIT];
            end

            batch.mask[ps2md_pkg::SLOT_MOTION] =
                !b0_reg[ps2md_pkg::X_OVF_BIT] && !b0_reg[ps2md_pkg::Y_OVF_BIT];
            batch.move_x = {b0_reg[ps2md_pkg::X_SIGN_BIT], b1_reg};
            batch.move_y = {b0_reg[ps2md_pkg::Y_SIGN_BIT], b2_eff};
            if (device_id == ps2md_pkg::ID_WHEEL)
                batch.move_wheel = b3;
            else if (five_button)
                batch.move_wheel = {{4{b3[3]}}, b3[3:0]};
            else
                batch.move_wheel = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= ps2md_pkg::POS_FIRST;
            b0_reg  <= '0;
            b1_reg  <= '0;
            b2_reg  <= '0;
            btn_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            b0_reg  <= b0_next;
            b1_reg  <= b1_next;
            b2_reg  <= b2_next;
            btn_reg <= btn_next;
        end
    end

endmodule

// File: src/ps2_mouse_packet_decoder_unit.sv
// ----------------------------------------------------------------------------
// ps2_mouse_packet_decoder_unit
// PS/2 mouse packet decoder with wheel and five-button support.
// ----------------------------------------------------------------------------
// A byte that does not complete a packet leaves the input ready, and the next
// byte may follow in the next cycle. A byte that completes a packet yields up
// to six events (button changes in order 0, 1, 2, 4, 5, then motion), which
// leave one per cycle from an output register while the sink keeps ready high;
// new bytes are held off until all events of the packet have moved into that
// register. device_id must be written through cfg_wr_en / cfg_wr_data only
// while the block is idle; the block itself does not enforce this.
module ps2_mouse_packet_decoder_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    ps2md_byte_if.sink       in_ch,
    ps2md_event_if.source    out_ch
);

    logic [7:0]              device_id_reg;
    ps2md_pkg::ps2md_batch_t batch;
    logic                    in_xfer;

    logic [ps2md_pkg::NUM_SLOTS-1:0] pend_mask_reg, pend_mask_next;
    logic [ps2md_pkg::NUM_SLOTS-2:0] pend_down_reg;
    logic signed [8:0]               pend_x_reg;
    logic signed [8:0]               pend_y_reg;
    logic signed [7:0]               pend_wheel_reg;

    logic                    out_valid_reg, out_valid_next;
    logic                    out_kind_reg;
    logic [2:0]              out_idx_reg;
    logic                    out_pressed_reg;
    logic signed [8:0]       out_x_reg;
    logic signed [8:0]       out_y_reg;
    logic signed [7:0]       out_wheel_reg;
    logic                    out_last_reg;

    logic                                load;
    logic [2:0]                          slot;
    logic [ps2md_pkg::NUM_SLOTS-1:0]     lowest;
    logic [ps2md_pkg::NUM_SLOTS-1:0]     rest;

    assign in_ch.ready = (pend_mask_reg == '0);
    assign in_xfer     = in_ch.valid && in_ch.ready;

    ps2md_assembler u_assembler (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_xfer),
        .data_byte (in_ch.data_byte),
        .from_aux  (in_ch.from_aux),
        .device_id (device_id_reg),
        .batch     (batch)
    );

    // Pick the lowest pending slot
    always_comb
    begin
        slot = 3'd0;
        for (int i = ps2md_pkg::NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (pend_mask_reg[i])
                slot = 3'(i);
        end
        lowest = pend_mask_reg & (~pend_mask_reg + 1'b1);
        rest   = pend_mask_reg & ~lowest;
    end

    assign load = (pend_mask_reg != '0) && (!out_valid_reg || out_ch.ready);

    always_comb
    begin
        pend_mask_next = pend_mask_reg;
        if (in_xfer)
            pend_mask_next = batch.mask;
        else if (load)
            pend_mask_next = rest;

        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_id_reg <= ps2md_pkg::ID_STANDARD;
            pend_mask_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                device_id_reg <= cfg_wr_data;
            pend_mask_reg <= pend_mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Batch payload and output payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            pend_down_reg  <= batch.down;
            pend_x_reg     <= batch.move_x;
            pend_y_reg     <= batch.move_y;
            pend_wheel_reg <= batch.move_wheel;
        end
        if (load)
        begin
            out_last_reg <= (rest == '0);
            if (slot == 3'(ps2md_pkg::SLOT_MOTION))
            begin
                out_kind_reg    <= ps2md_pkg::EVENT_MOTION;
                out_idx_reg     <= 3'd0;
                out_pressed_reg <= 1'b0;
                out_x_reg       <= pend_x_reg;
                out_y_reg       <= pend_y_reg;
                out_wheel_reg   <= pend_wheel_reg;
            end
            else
            begin
                out_kind_reg    <= ps2md_pkg::EVENT_BUTTON;
                out_idx_reg     <= ps2md_pkg::slot_button(slot);
                out_pressed_reg <= pend_down_reg[slot];
                out_x_reg       <= '0;
                out_y_reg       <= '0;
                out_wheel_reg   <= '0;
            end
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.event_kind   = out_kind_reg;
    assign out_ch.button_index = out_idx_reg;
    assign out_ch.pressed      = out_pressed_reg;
    assign out_ch.move_x       = out_x_reg;
    assign out_ch.move_y       = out_y_reg;
    assign out_ch.move_wheel   = out_wheel_reg;
    assign out_ch.last         = out_last_reg;

    // Pending events only drain until the batch is empty
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_mask_reg != '0 |=>
            $countones(pend_mask_reg) <= $countones($past(pend_mask_reg)))
        else $error("pending event set grew while draining");

    // A motion event never carries button fields
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.event_kind == ps2md_pkg::EVENT_MOTION |->
            out_ch.button_index == 3'd0 && !out_ch.pressed)
        else $error("motion event with button fields");

    // A button event names a real button and carries no motion
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.event_kind == ps2md_pkg::EVENT_BUTTON |->
            out_ch.button_index != 3'd3 && out_ch.button_index <= 3'd5
            && out_ch.move_x == '0 && out_ch.move_y == '0 && out_ch.move_wheel == '0)
        else $error("malformed button event");

    // The last event of a packet leaves nothing pending; no byte can arrive while events are pending
    assert property (@(posedge clk) disable iff (!rst_n)
        load && rest == '0 |=> pend_mask_reg == '0)
        else $error("events left pending after last");

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks the PS/2 mouse packet decoder: feeds controller bytes and compares
// each button and motion event against a cycle-free decode of the same
// stream, across several mouse ids, with bursty input and a stalling sink.
// ----------------------------------------------------------------------------
module tb;

    localparam int SETTLE_CYCLES = 12;
    localparam int STALL_LIMIT   = 3000;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 72;
    localparam int MAX_PRINTS    = 50;

    typedef struct packed {
        logic [7:0] data;
        logic       aux;
    } ctrl_byte_t;

    typedef struct packed {
        ps2md_pkg::ps2md_kind_t kind;
        logic [2:0]             button;
        logic                   pressed;
        logic signed [8:0]      dx;
        logic signed [8:0]      dy;
        logic signed [7:0]      dw;
        logic                   last;
    } mouse_event_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic [7:0] cfg_wr_data = 8'h00;

    ps2md_byte_if  in_ch ();
    ps2md_event_if out_ch ();

    ps2_mouse_packet_decoder_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch)
    );

    // Decoder state as the predictor sees it
    logic [7:0]            mouse_id = ps2md_pkg::ID_STANDARD;
    ps2md_pkg::ps2md_pos_t pkt_pos = ps2md_pkg::POS_FIRST;
    logic [7:0]            pkt_bytes [3] = '{8'h00, 8'h00, 8'h00};
    logic [5:0]            btn_down = '0;

    mouse_event_t expected_events [$];
    ctrl_byte_t   pending_bytes [$];

    // Generator-side view of the packet position, used to keep packets aligned
    logic [7:0]            gen_id = ps2md_pkg::ID_STANDARD;
    ps2md_pkg::ps2md_pos_t gen_pos = ps2md_pkg::POS_FIRST;

    int  bytes_queued = 0;
    int  aux_queued = 0;
    int  bytes_done = 0;
    int  err_cnt = 0;
    int  burst_left = 0;
    int  gap_left = 0;
    int  stall_left = 0;
    int  cycle_cnt = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    bit  hold_armed = 1'b0;
    bit  offering;
    ctrl_byte_t   next_item;
    mouse_event_t want;

    initial
    begin
        forever #1 clk = ~clk;
    end

    task automatic report(input string msg);
        err_cnt++;
        if (err_cnt <= MAX_PRINTS)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    task automatic button_change(input logic [2:0] idx, input logic now, inout int added);
        mouse_event_t ev;
        if (btn_down[idx] != now)
        begin
            ev = '0;
            ev.kind = ps2md_pkg::EVENT_BUTTON;
            ev.button = idx;
            ev.pressed = now;
            expected_events.push_back(ev);
            added++;
        end
        btn_down[idx] = now;
    endtask

    task automatic complete_packet(input logic [7:0] b3);
        mouse_event_t ev;
        int added;
        added = 0;
        for (int i = 0; i < 3; i++)
            button_change(3'(i), pkt_bytes[0][i], added);
        if (mouse_id == ps2md_pkg::ID_FIVE_BUTTON)
        begin
            button_change(3'd4, b3[ps2md_pkg::BTN4_BIT], added);
            button_change(3'd5, b3[ps2md_pkg::BTN5_BIT], added);
        end
        if (!pkt_bytes[0][ps2md_pkg::X_OVF_BIT] && !pkt_bytes[0][ps2md_pkg::Y_OVF_BIT])
        begin
            ev = '0;
            ev.kind = ps2md_pkg::EVENT_MOTION;
            ev.dx = {pkt_bytes[0][ps2md_pkg::X_SIGN_BIT], pkt_bytes[1]};
            ev.dy = {pkt_bytes[0][ps2md_pkg::Y_SIGN_BIT], pkt_bytes[2]};
            if (mouse_id == ps2md_pkg::ID_WHEEL)
                ev.dw = b3;
            else if (mouse_id == ps2md_pkg::ID_FIVE_BUTTON)
                ev.dw = {{4{b3[3]}}, b3[3:0]};
            expected_events.push_back(ev);
            added++;
        end
        pkt_pos = ps2md_pkg::POS_FIRST;
        if (added > 0)
            expected_events[expected_events.size() - 1].last = 1'b1;
    endtask

    task automatic decode_byte(input logic [7:0] d, input logic aux);
        if (!aux)
            return;
        case (pkt_pos)
            ps2md_pkg::POS_FIRST:
            begin
                // drop bytes without the sync bit to regain alignment
                if (d[ps2md_pkg::SYNC_BIT])
                begin
                    pkt_bytes[0] = d;
                    pkt_pos = ps2md_pkg::POS_SECOND;
                end
            end
            ps2md_pkg::POS_SECOND:
            begin
                pkt_bytes[1] = d;
                pkt_pos = ps2md_pkg::POS_THIRD;
            end
            ps2md_pkg::POS_THIRD:
            begin
                pkt_bytes[2] = d;
                if (mouse_id != ps2md_pkg::ID_STANDARD)
                    pkt_pos = ps2md_pkg::POS_FOURTH;
                else
                    complete_packet(8'h00);
            end
            default:
                complete_packet(d);
        endcase
    endtask

    task automatic queue_byte(input logic [7:0] d, input logic aux);
        ctrl_byte_t item;
        item.data = d;
        item.aux = aux;
        pending_bytes.push_back(item);
        bytes_queued++;
        if (aux)
        begin
            aux_queued++;
            case (gen_pos)
                ps2md_pkg::POS_FIRST:
                    if (d[ps2md_pkg::SYNC_BIT]) gen_pos = ps2md_pkg::POS_SECOND;
                ps2md_pkg::POS_SECOND:
                    gen_pos = ps2md_pkg::POS_THIRD;
                ps2md_pkg::POS_THIRD:
                    gen_pos = (gen_id != ps2md_pkg::ID_STANDARD) ?
                              ps2md_pkg::POS_FOURTH : ps2md_pkg::POS_FIRST;
                default:
                    gen_pos = ps2md_pkg::POS_FIRST;
            endcase
        end
    endtask

    task automatic queue_packet(input logic [7:0] b0, input logic [7:0] b1,
                                input logic [7:0] b2, input logic [7:0] b3);
        queue_byte(b0, 1'b1);
        queue_byte(b1, 1'b1);
        queue_byte(b2, 1'b1);
        if (gen_id != ps2md_pkg::ID_STANDARD)
            queue_byte(b3, 1'b1);
    endtask

    task automatic wait_idle();
        while (bytes_done != bytes_queued || expected_events.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_mouse_id(input logic [7:0] id);
        wait_idle();
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= id;
        mouse_id = id;
        gen_id = id;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    task automatic queue_random(input int count);
        int start;
        int pick;
        logic [7:0] b0;
        start = aux_queued;
        while (aux_queued - start < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                // finish any partial packet with random bytes first
                while (gen_pos != ps2md_pkg::POS_FIRST)
                    queue_byte(8'($urandom), 1'b1);
                b0 = 8'($urandom);
                b0[ps2md_pkg::SYNC_BIT] = 1'b1;
                if ($urandom_range(0, 3) != 0)
                    b0[ps2md_pkg::Y_OVF_BIT:ps2md_pkg::X_OVF_BIT] = 2'b00;
                queue_packet(b0, 8'($urandom), 8'($urandom), 8'($urandom));
            end
            else if (pick < 80)
                queue_byte(8'($urandom), 1'b0);
            else if (pick < 90)
                queue_byte(8'($urandom), 1'b1);
            else
            begin
                // truncated packet start
                b0 = 8'($urandom);
                b0[ps2md_pkg::SYNC_BIT] = 1'b1;
                queue_byte(b0, 1'b1);
                if ($urandom_range(0, 1) != 0)
                    queue_byte(8'($urandom), 1'b1);
            end
        end
    endtask

    // Byte driver: bursts of random length separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.data_byte <= 8'h00;
            in_ch.from_aux <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            offering = in_ch.valid;
            if (in_ch.valid && in_ch.ready)
            begin
                decode_byte(in_ch.data_byte, in_ch.from_aux);
                bytes_done++;
                offering = 1'b0;
            end
            if (!offering)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_ch.valid <= 1'b0;
                end
                else if (pending_bytes.size() > 0)
                begin
                    next_item = pending_bytes.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.data_byte <= next_item.data;
                    in_ch.from_aux <= next_item.aux;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 15);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // Long sink hold-off, once, while the sender keeps offering bytes
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_armed && !hold_done)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // Event monitor and sink stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            stall_left = 0;
            cycle_cnt = 0;
        end
        else
        begin
            cycle_cnt++;
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_events.size() == 0)
                    report($sformatf("event with nothing expected: kind=%0d btn=%0d",
                                     out_ch.event_kind, out_ch.button_index));
                else
                begin
                    want = expected_events.pop_front();
                    if (out_ch.event_kind !== want.kind || out_ch.button_index !== want.button ||
                        out_ch.pressed !== want.pressed || out_ch.move_x !== want.dx ||
                        out_ch.move_y !== want.dy || out_ch.move_wheel !== want.dw ||
                        out_ch.last !== want.last)
                        report($sformatf({"got kind=%0d btn=%0d down=%0d x=%0d y=%0d w=%0d last=%0d",
                                          " want kind=%0d btn=%0d down=%0d x=%0d y=%0d w=%0d last=%0d"},
                                         out_ch.event_kind, out_ch.button_index, out_ch.pressed,
                                         out_ch.move_x, out_ch.move_y, out_ch.move_wheel,
                                         out_ch.last, want.kind, want.button, want.pressed,
                                         want.dx, want.dy, want.dw, want.last));
                end
            end
            // quiet windows with ready held high, short random stalls elsewhere
            if (stall_left > 0)
                stall_left--;
            else if ((cycle_cnt % 1000) >= 250 && $urandom_range(0, 3) == 0)
                stall_left = $urandom_range(1, 6);
            out_ch.ready <= (stall_left == 0) && (hold_left == 0);
        end
    end

    // Watchdog: end the run when no transfer happens for too long
    initial
    begin
        int stuck;
        stuck = 0;
        while (stuck < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_wr_en)
                stuck = 0;
            else
                stuck++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        logic [7:0] phase_ids [6];
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Three-byte mouse: noise, resync drop, press all, release under overflow,
        // sign extremes, and a packet that causes no event at all
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'hF7, 1'b1);
        queue_packet(8'h0F, 8'hFF, 8'h00, 8'h00);
        queue_packet(8'hC8, 8'h12, 8'h34, 8'h00);
        queue_packet(8'h38, 8'h00, 8'hFF, 8'h00);
        queue_packet(8'h88, 8'h55, 8'hAA, 8'h00);

        // Id switched to wheel at the third position: packet grows to four bytes
        queue_byte(8'h09, 1'b1);
        queue_byte(8'h10, 1'b1);
        set_mouse_id(ps2md_pkg::ID_WHEEL);
        queue_byte(8'h20, 1'b1);
        queue_byte(8'h80, 1'b1);

        // Id switched at the fourth position: the new id decodes the last byte
        queue_byte(8'h08, 1'b1);
        queue_byte(8'h7F, 1'b1);
        queue_byte(8'h81, 1'b1);
        set_mouse_id(ps2md_pkg::ID_FIVE_BUTTON);
        queue_byte(8'h3F, 1'b1);

        // Id cleared at the third position: the third byte completes the packet
        queue_byte(8'h0A, 1'b1);
        queue_byte(8'h01, 1'b1);
        set_mouse_id(ps2md_pkg::ID_STANDARD);
        queue_byte(8'hFE, 1'b1);

        // Four-byte mouse without wheel
        set_mouse_id(8'hFF);
        queue_packet(8'h0C, 8'h03, 8'h04, 8'h7F);

        phase_ids[0] = ps2md_pkg::ID_STANDARD;
        phase_ids[1] = ps2md_pkg::ID_WHEEL;
        phase_ids[2] = ps2md_pkg::ID_FIVE_BUTTON;
        phase_ids[3] = 8'hFF;
        phase_ids[4] = 8'($urandom_range(5, 254));
        phase_ids[5] = ps2md_pkg::ID_FIVE_BUTTON;
        for (int p = 0; p < 6; p++)
        begin
            set_mouse_id(phase_ids[p]);
            queue_random(PHASE_ITEMS);
            if (p == 2)
                hold_armed = 1'b1;
        end

        wait_idle();
        if (expected_events.size() != 0)
            report($sformatf("%0d events never arrived", expected_events.size()));
        if (err_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: filelist.f
src/ps2md_pkg.sv
src/ps2md_byte_if.sv
src/ps2md_event_if.sv
src/ps2md_assembler.sv
src/ps2_mouse_packet_decoder_unit.sv
tb/sv/tb.sv
